>>> src/rlim_pkg.sv
package rlim_pkg;

  localparam int AddrW  = 32;
  localparam int TimeW  = 32;
  localparam int WinW   = 17;
  localparam int MaxW   = 16;
  localparam int CountW = 17;
  localparam int VerdW  = 3;
  localparam int EvictW = 7;
  localparam int CfgIdxW = 3;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};
  localparam logic [EvictW-1:0] EvictMax = {EvictW{1'b1}};

  localparam logic [VerdW-1:0] VerdPass    = 3'd0;
  localparam logic [VerdW-1:0] VerdAllowed = 3'd1;
  localparam logic [VerdW-1:0] VerdBad     = 3'd2;
  localparam logic [VerdW-1:0] VerdTooMany = 3'd3;
  localparam logic [VerdW-1:0] VerdFull    = 3'd4;

  localparam logic ActRequest = 1'b0;
  localparam logic ActSweep   = 1'b1;

  localparam logic [CfgIdxW-1:0] RegWindow  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMax     = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAllow0  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAllow1  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegAllow2  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegAllow3  = 3'd5;

  // item traveling down the cell row
  typedef struct packed {
    logic              vld;
    logic              action;
    logic [AddrW-1:0]  addr;
    logic [TimeW-1:0]  now;
    logic              done;
    logic              free_found;
    logic [VerdW-1:0]  verdict;
    logic [EvictW-1:0] evicted;
  } tok_t;

  // entry creation broadcast
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [TimeW-1:0] now;
  } create_t;

endpackage

>>> src/rlim_cell.sv
module rlim_cell import rlim_pkg::*; #(
  parameter int IDX_W = 6,
  parameter int MY_IDX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [WinW-1:0]  window_i,
  input  logic [MaxW-1:0]  max_i,
  input  tok_t             tok_i,
  input  logic [IDX_W-1:0] idx_i,
  input  create_t          create_i,
  input  logic [IDX_W-1:0] create_idx_i,
  output tok_t             tok_o,
  output logic [IDX_W-1:0] idx_o
);

  logic              valid_q, valid_d;
  logic [AddrW-1:0]  addr_q, addr_d;
  logic [CountW-1:0] count_q, count_d;
  logic [TimeW-1:0]  start_q, start_d;
  tok_t              tok_q, tok_d;
  logic [IDX_W-1:0]  idx_q, idx_d;

  logic [TimeW-1:0]  elapsed;
  logic              expired;
  logic [CountW-1:0] count_inc;
  localparam logic [IDX_W-1:0] MyIdx = IDX_W'(MY_IDX);

  assign elapsed   = tok_i.now - start_q;
  assign expired   = elapsed > {{(TimeW-WinW){1'b0}}, window_i};
  assign count_inc = (count_q == CountMax) ? count_q : count_q + 1'b1;

  always_comb begin
    valid_d = valid_q;
    addr_d  = addr_q;
    count_d = count_q;
    start_d = start_q;
    tok_d   = tok_i;
    idx_d   = idx_i;
    if (tok_i.vld) begin
      if (tok_i.action == ActRequest) begin
        if (!tok_i.done && valid_q && addr_q == tok_i.addr) begin
          tok_d.done = 1'b1;
          if (expired) begin
            count_d = CountW'(1);
            start_d = tok_i.now;
            tok_d.verdict = VerdPass;
          end else begin
            count_d = count_inc;
            tok_d.verdict = (count_inc > {1'b0, max_i}) ? VerdTooMany : VerdPass;
          end
        end else if (!valid_q && !tok_i.free_found) begin
          tok_d.free_found = 1'b1;
          idx_d = MyIdx;
        end
      end else if (valid_q && expired) begin
        valid_d = 1'b0;
        if (tok_i.evicted != EvictMax) tok_d.evicted = tok_i.evicted + 1'b1;
      end
    end
    if (create_i.en && create_idx_i == MyIdx) begin
      valid_d = 1'b1;
      addr_d  = create_i.addr;
      count_d = CountW'(1);
      start_d = create_i.now;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      tok_q   <= '0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    count_q <= count_d;
    start_q <= start_d;
    idx_q   <= idx_d;
  end

  assign tok_o = tok_q;
  assign idx_o = idx_q;

endmodule

>>> src/per_address_rate_limiter_unit.sv
// Per-address fixed-window rate limiter.
// Input stream s_axis: tdata = client address (bits 31:0) and time in seconds
// (bits 63:32); tuser = action (0 request check, 1 sweep expired entries).
// Output stream m_axis: tdata = verdict (2:0), evicted count (9:3), zero pad.
// Config channel cfg_*: index 0 window, 1 max requests, 2..5 allowed list;
// cfg_ready_o is always high; the user makes writes only while the block is
// idle, which the block itself does not enforce. Each table entry lives in
// one cell of a row of TABLE_ENTRIES cells; an item walks the row one cell
// per cycle, passing the input register and every cell register before its
// result reaches the output register. No new item is taken until the previous
// one has left the row. A new entry is written in the cycle the item leaves
// the row.
// Reset clears all entry valid bits and loads register defaults at once.
// When the receiver stalls, one finished result waits in the output register
// and one more in a holding register; no new item is taken while that is full.
module per_address_rate_limiter_unit import rlim_pkg::*; #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [63:0]        s_axis_tdata,  // client_addr, now_seconds
  input  logic               s_axis_tuser,  // action
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [15:0]        m_axis_tdata,  // verdict, evicted_count, pad
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [WinW-1:0]  window_q;
  logic [MaxW-1:0]  max_q;
  logic [AddrW-1:0] allow_q [4];

  logic busy_q, pend_q, mval_q;
  logic [VerdW+EvictW-1:0] mres_q, pres_q, res;

  tok_t            tok_q;
  tok_t            tok_c [TABLE_ENTRIES+1];
  logic [IdxW-1:0] idx_c [TABLE_ENTRIES+1];
  create_t         create;
  tok_t            tok_end;
  logic            accept, exit_vld, out_free;
  logic            in_bad, in_allow;
  logic [AddrW-1:0] in_addr;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !busy_q && !pend_q;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_addr       = s_axis_tdata[31:0];
  assign in_bad        = in_addr == '0;
  assign in_allow      = allow_q[0] == in_addr || allow_q[1] == in_addr ||
                         allow_q[2] == in_addr || allow_q[3] == in_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= WinW'(60);
      max_q    <= MaxW'(100);
      for (int i = 0; i < 4; i++) allow_q[i] <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegWindow: window_q   <= cfg_data_i[WinW-1:0];
        RegMax:    max_q      <= cfg_data_i[MaxW-1:0];
        RegAllow0: allow_q[0] <= cfg_data_i;
        RegAllow1: allow_q[1] <= cfg_data_i;
        RegAllow2: allow_q[2] <= cfg_data_i;
        RegAllow3: allow_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q.vld <= accept;
      if (accept) begin
        tok_q.action     <= s_axis_tuser;
        tok_q.addr       <= in_addr;
        tok_q.now        <= s_axis_tdata[63:32];
        tok_q.done       <= (s_axis_tuser == ActRequest) && (in_bad || in_allow);
        tok_q.free_found <= 1'b0;
        tok_q.verdict    <= in_bad ? VerdBad : (in_allow ? VerdAllowed : VerdPass);
        tok_q.evicted    <= '0;
      end
    end
  end

  assign tok_c[0] = tok_q;
  assign idx_c[0] = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    rlim_cell #(.IDX_W(IdxW), .MY_IDX(g)) u_cell (
      .clk_i, .rst_ni,
      .window_i     (window_q),
      .max_i        (max_q),
      .tok_i        (tok_c[g]),
      .idx_i        (idx_c[g]),
      .create_i     (create),
      .create_idx_i (idx_c[TABLE_ENTRIES]),
      .tok_o        (tok_c[g+1]),
      .idx_o        (idx_c[g+1])
    );
  end

  assign tok_end  = tok_c[TABLE_ENTRIES];
  assign exit_vld = tok_end.vld;

  always_comb begin
    create.en   = exit_vld && tok_end.action == ActRequest && !tok_end.done &&
                  tok_end.free_found;
    create.addr = tok_end.addr;
    create.now  = tok_end.now;
    if (tok_end.action == ActSweep) begin
      res = {tok_end.evicted, VerdPass};
    end else if (tok_end.done) begin
      res = {{EvictW{1'b0}}, tok_end.verdict};
    end else begin
      res = {{EvictW{1'b0}}, tok_end.free_found ? VerdPass : VerdFull};
    end
  end

  assign out_free = !mval_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pend_q <= 1'b0;
      mval_q <= 1'b0;
    end else begin
      if (accept) busy_q <= 1'b1;
      else if (exit_vld) busy_q <= 1'b0;
      if (out_free) begin
        mval_q <= pend_q || exit_vld;
        pend_q <= pend_q && exit_vld;
      end else if (exit_vld) begin
        pend_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (pend_q) begin
        mres_q <= pres_q;
        if (exit_vld) pres_q <= res;
      end else if (exit_vld) begin
        mres_q <= res;
      end
    end else if (exit_vld) begin
      pres_q <= res;
    end
  end

  assign m_axis_tvalid = mval_q;
  assign m_axis_tdata  = {{(16-VerdW-EvictW){1'b0}}, mres_q};

  a_pend_has_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> mval_q) else $error("holding register full with output empty");
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_q) else $error("accepted item not marked busy");
  a_exit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_vld |-> busy_q) else $error("item left cell row while idle");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !s_axis_tready) else $error("ready while an item is in flight");

endmodule
